// ===== rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants of the per-source connection limiter
// Table geometry, configuration register indexes, result codes, channel
// payload structs and the controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int STAT_W        = (CNT_W > 7) ? CNT_W : 7;
  localparam int KEY_W         = 64;
  localparam int COUNT_W       = 16;
  localparam int ROW_W         = 2 * KEY_W + COUNT_W;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_PER_SOURCE = 1'b0,
    REG_MAX_TOTAL      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_GLOBAL     = 3'd1,
    STAT_PER_SOURCE = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_UNKNOWN    = 3'd4
  } status_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] addr_upper;
    logic [KEY_W-1:0] addr_lower;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COUNT_W-1:0] total_active;
    logic [6:0]         sources_in_use;
    logic [6:0]         sources_saturated;
    logic [COUNT_W-1:0] busiest_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic apply;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [6:0] sat_stat(input logic [CNT_W-1:0] v);
    logic [STAT_W-1:0] w;
    w = STAT_W'(v);
    if (w > STAT_W'(127)) begin
      return 7'd127;
    end
    return w[6:0];
  endfunction

endpackage

// ===== rtl/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl: sequencing state machine of the connection limiter
// Takes one beat, runs the table scan, then applies the update once the
// result register is free.
// ----------------------------------------------------------------------------
module plc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plc_pkg::dp_status_t status,
  output plc_pkg::dp_cmd_t    cmd
);

  plc_pkg::ctrl_state_t state_r;
  plc_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      plc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = plc_pkg::S_SCAN;
        end
      end
      plc_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = plc_pkg::S_APPLY;
        end
      end
      plc_pkg::S_APPLY: begin
        if (status.out_free) begin
          cmd.apply = 1'b1;
          state_nxt = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/plc_datapath.sv =====
// ----------------------------------------------------------------------------
// plc_datapath: entry table, scan accumulators and result register
// Holds keys and counts in a single-port-read memory, valid bits in flops,
// the global count and the limit registers.
// ----------------------------------------------------------------------------
module plc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plc_pkg::dp_cmd_t                     cmd,
  output plc_pkg::dp_status_t                  status,
  input  plc_pkg::in_item_t                    in_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output plc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [plc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int IW = plc_pkg::IDX_W;
  localparam int CW = plc_pkg::CNT_W;
  localparam int NW = plc_pkg::COUNT_W;
  localparam int KW = plc_pkg::KEY_W;

  logic [plc_pkg::ROW_W-1:0] mem [plc_pkg::TABLE_ENTRIES];

  logic [NW-1:0]                      max_per_source_r;
  logic [NW-1:0]                      max_total_r;
  logic [plc_pkg::TABLE_ENTRIES-1:0]  used_r;
  logic [NW-1:0]                      global_r;
  plc_pkg::in_item_t                  item_r;

  logic [IW:0]               scan_cnt_r;
  logic                      scan_done;
  logic [IW-1:0]             rd_addr;
  logic [plc_pkg::ROW_W-1:0] rd_row_r;
  logic                      rd_used_r;
  logic [IW-1:0]             rd_idx_r;
  logic                      rd_vld_r;
  logic [KW-1:0]             rd_key_up;
  logic [KW-1:0]             rd_key_lo;
  logic [NW-1:0]             rd_cnt;

  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [NW-1:0] hit_cnt_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic [CW-1:0] use_cnt_r;
  logic [CW-1:0] sat_cnt_r;
  logic [NW-1:0] max1_r;
  logic [IW-1:0] max1_idx_r;
  logic [NW-1:0] max2_r;

  logic               out_valid_r;
  plc_pkg::out_item_t out_data_r;

  plc_pkg::status_t  res_status;
  logic              wr_en;
  logic              alloc;
  logic              modify;
  logic              freed;
  logic [NW-1:0]     cur_cnt;
  logic [NW-1:0]     new_cnt;
  logic [NW-1:0]     global_nxt;
  logic [IW-1:0]     tgt_idx;
  logic [NW-1:0]     other_max;
  logic [CW-1:0]     in_use_c;
  logic [CW-1:0]     sat_c;
  logic [NW-1:0]     busy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_per_source_r <= NW'(4);
      max_total_r      <= NW'(256);
    end else if (cfg_we) begin
      case (plc_pkg::cfg_reg_t'(cfg_addr))
        plc_pkg::REG_MAX_PER_SOURCE: max_per_source_r <= cfg_wdata;
        plc_pkg::REG_MAX_TOTAL:      max_total_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign scan_done = (scan_cnt_r == (IW + 1)'(plc_pkg::TABLE_ENTRIES));
  assign rd_addr   = scan_cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan && !scan_done) begin
        scan_cnt_r <= scan_cnt_r + (IW + 1)'(1);
      end
      rd_vld_r <= cmd.scan && !scan_done;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r  <= mem[rd_addr];
    rd_used_r <= used_r[rd_addr];
    rd_idx_r  <= rd_addr;
    if (cmd.apply && wr_en) begin
      mem[tgt_idx] <= {item_r.addr_upper, item_r.addr_lower, new_cnt};
    end
  end

  assign rd_key_up = rd_row_r[plc_pkg::ROW_W-1 -: KW];
  assign rd_key_lo = rd_row_r[NW +: KW];
  assign rd_cnt    = rd_row_r[NW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r       <= in_data;
      hit_r        <= 1'b0;
      hit_idx_r    <= '0;
      hit_cnt_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      use_cnt_r    <= '0;
      sat_cnt_r    <= '0;
      max1_r       <= '0;
      max1_idx_r   <= '0;
      max2_r       <= '0;
    end else if (rd_vld_r) begin
      if (rd_used_r) begin
        if (rd_key_up == item_r.addr_upper && rd_key_lo == item_r.addr_lower) begin
          hit_r     <= 1'b1;
          hit_idx_r <= rd_idx_r;
          hit_cnt_r <= rd_cnt;
        end
        use_cnt_r <= use_cnt_r + CW'(1);
        if (rd_cnt >= max_per_source_r) begin
          sat_cnt_r <= sat_cnt_r + CW'(1);
        end
        if (rd_cnt > max1_r) begin
          max2_r     <= max1_r;
          max1_r     <= rd_cnt;
          max1_idx_r <= rd_idx_r;
        end else if (rd_cnt > max2_r) begin
          max2_r <= rd_cnt;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  assign cur_cnt = hit_r ? hit_cnt_r : '0;
  assign tgt_idx = hit_r ? hit_idx_r : free_idx_r;

  always_comb begin
    res_status = plc_pkg::STAT_OK;
    wr_en      = 1'b0;
    alloc      = 1'b0;
    modify     = 1'b0;
    freed      = 1'b0;
    new_cnt    = cur_cnt;
    global_nxt = global_r;
    if (item_r.action == plc_pkg::ACT_ACQUIRE) begin
      if (global_r >= max_total_r) begin
        res_status = plc_pkg::STAT_GLOBAL;
      end else if (cur_cnt >= max_per_source_r) begin
        res_status = plc_pkg::STAT_PER_SOURCE;
      end else if (!hit_r && !free_found_r) begin
        res_status = plc_pkg::STAT_FULL;
      end else begin
        wr_en      = 1'b1;
        alloc      = !hit_r;
        modify     = hit_r;
        new_cnt    = cur_cnt + NW'(1);
        global_nxt = global_r + NW'(1);
      end
    end else begin
      if (!hit_r) begin
        res_status = plc_pkg::STAT_UNKNOWN;
      end else begin
        wr_en      = 1'b1;
        modify     = 1'b1;
        new_cnt    = (hit_cnt_r != '0) ? hit_cnt_r - NW'(1) : '0;
        global_nxt = (global_r != '0) ? global_r - NW'(1) : '0;
        freed      = (new_cnt == '0);
      end
    end
  end

  always_comb begin
    other_max = (max1_idx_r == hit_idx_r) ? max2_r : max1_r;
    in_use_c  = use_cnt_r;
    sat_c     = sat_cnt_r;
    busy_c    = max1_r;
    if (alloc) begin
      in_use_c = use_cnt_r + CW'(1);
      if (new_cnt >= max_per_source_r) begin
        sat_c = sat_cnt_r + CW'(1);
      end
      busy_c = (max1_r > new_cnt) ? max1_r : new_cnt;
    end else if (modify) begin
      if (freed) begin
        in_use_c = use_cnt_r - CW'(1);
      end
      if (!freed && new_cnt >= max_per_source_r) begin
        sat_c = sat_c + CW'(1);
      end
      if (hit_cnt_r >= max_per_source_r) begin
        sat_c = sat_c - CW'(1);
      end
      busy_c = (other_max > new_cnt) ? other_max : new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      global_r <= '0;
    end else if (cmd.apply && wr_en) begin
      used_r[tgt_idx] <= !freed;
      global_r        <= global_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_data_r.status            <= res_status;
      out_data_r.total_active      <= global_nxt;
      out_data_r.sources_in_use    <= plc_pkg::sat_stat(in_use_c);
      out_data_r.sources_saturated <= plc_pkg::sat_stat(sat_c);
      out_data_r.busiest_count     <= busy_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.scan_done = scan_done;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/per_source_connection_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_limiter: admission counter table keyed by source
// Counts open connections per 128-bit source address and in total, and
// reports the table statistics with every result.
//
//   Channel | Dir | Handshake            | Payload
//   in      | in  | in_valid / in_ready   | in_data  (action, addr_upper, addr_lower)
//   out     | out | out_valid / out_ready | out_data (status, counts, statistics)
//   cfg     | in  | cfg_we                | cfg_addr, cfg_wdata
//
// A beat passes through the accept, one read of every entry through the
// single read port of the entry memory, a step that folds in the last
// registered read, then the apply step that performs the update and
// loads the result register.
// Reset is synchronous and clears the entry valid bits at once; no clearing
// pass runs. The apply cycle waits while an earlier result is still held.
// ----------------------------------------------------------------------------
module per_source_connection_limiter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  plc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output plc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [plc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [plc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  plc_pkg::dp_cmd_t    cmd;
  plc_pkg::dp_status_t status;

  plc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  plc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== rtl/plc_checker.sv =====
// ----------------------------------------------------------------------------
// plc_checker: port-level checks of the connection limiter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module plc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input plc_pkg::out_item_t out_data
);

  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.sources_in_use == 7'd0) == (out_data.busiest_count == 16'd0)))
    else $error("busiest count disagrees with allocated entries");

  a_saturated_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sources_saturated <= out_data.sources_in_use)
    else $error("more saturated entries than allocated entries");

endmodule

bind per_source_connection_limiter plc_checker u_plc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/per_source_connection_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_limiter_tb: self-checking bench for the limiter
// Drives acquire and release beats keyed by 128-bit sources, predicts each
// result from a private copy of the table, counters and limits, and checks
// every result beat field by field. A directed part covers the refusal
// cases but a full table, then random phases with several limit settings and idle patterns
// fill the table, hit the global and per-source limits, and release again.
// ----------------------------------------------------------------------------
module per_source_connection_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE      = 100;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;

  class admission_scoreboard;
    logic                           slot_used [plc_pkg::TABLE_ENTRIES];
    logic [plc_pkg::KEY_W-1:0]      slot_up   [plc_pkg::TABLE_ENTRIES];
    logic [plc_pkg::KEY_W-1:0]      slot_lo   [plc_pkg::TABLE_ENTRIES];
    logic [plc_pkg::COUNT_W-1:0]    slot_cnt  [plc_pkg::TABLE_ENTRIES];
    logic [plc_pkg::COUNT_W-1:0]    open_total;
    logic [plc_pkg::CFG_DATA_W-1:0] per_source_cap;
    logic [plc_pkg::CFG_DATA_W-1:0] total_cap;
    plc_pkg::out_item_t             verdict_q [$];
    int                             errors;

    function new();
      int i;
      for (i = 0; i < plc_pkg::TABLE_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_up[i]   = '0;
        slot_lo[i]   = '0;
        slot_cnt[i]  = '0;
      end
      open_total     = '0;
      per_source_cap = 16'd4;
      total_cap      = 16'd256;
      errors         = 0;
    endfunction

    function void set_limit(plc_pkg::cfg_reg_t r, logic [plc_pkg::CFG_DATA_W-1:0] v);
      case (r)
        plc_pkg::REG_MAX_PER_SOURCE: per_source_cap = v;
        plc_pkg::REG_MAX_TOTAL:      total_cap = v;
        default: ;
      endcase
    endfunction

    function int find_source(logic [plc_pkg::KEY_W-1:0] up, logic [plc_pkg::KEY_W-1:0] lo);
      int i;
      for (i = 0; i < plc_pkg::TABLE_ENTRIES; i++) begin
        if (slot_used[i] && slot_up[i] == up && slot_lo[i] == lo) begin
          return i;
        end
      end
      return -1;
    endfunction

    function int free_slot();
      int i;
      for (i = 0; i < plc_pkg::TABLE_ENTRIES; i++) begin
        if (!slot_used[i]) begin
          return i;
        end
      end
      return -1;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Applies one accepted beat to the private table and queues its result.
    function void admit_beat(plc_pkg::in_item_t b);
      plc_pkg::status_t            st;
      plc_pkg::out_item_t          verdict;
      int                          idx;
      int                          i;
      int unsigned                 in_use;
      int unsigned                 saturated;
      logic [plc_pkg::COUNT_W-1:0] busiest;
      st  = plc_pkg::STAT_OK;
      idx = find_source(b.addr_upper, b.addr_lower);
      if (b.action == plc_pkg::ACT_ACQUIRE) begin
        if (open_total >= total_cap) begin
          st = plc_pkg::STAT_GLOBAL;
        end else if ((idx >= 0) ? (slot_cnt[idx] >= per_source_cap)
                                : (per_source_cap == '0)) begin
          st = plc_pkg::STAT_PER_SOURCE;
        end else if (idx < 0 && free_slot() < 0) begin
          st = plc_pkg::STAT_FULL;
        end else begin
          if (idx < 0) begin
            idx = free_slot();
            slot_used[idx] = 1'b1;
            slot_up[idx]   = b.addr_upper;
            slot_lo[idx]   = b.addr_lower;
            slot_cnt[idx]  = '0;
          end
          slot_cnt[idx] = slot_cnt[idx] + 16'd1;
          open_total    = open_total + 16'd1;
        end
      end else if (idx < 0) begin
        st = plc_pkg::STAT_UNKNOWN;
      end else begin
        if (slot_cnt[idx] != '0) begin
          slot_cnt[idx] = slot_cnt[idx] - 16'd1;
        end
        if (open_total != '0) begin
          open_total = open_total - 16'd1;
        end
        if (slot_cnt[idx] == '0) begin
          slot_used[idx] = 1'b0;
        end
      end
      in_use    = 0;
      saturated = 0;
      busiest   = '0;
      for (i = 0; i < plc_pkg::TABLE_ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (in_use < 127) begin
            in_use++;
          end
          if (slot_cnt[i] >= per_source_cap && saturated < 127) begin
            saturated++;
          end
          if (slot_cnt[i] > busiest) begin
            busiest = slot_cnt[i];
          end
        end
      end
      verdict.status            = st;
      verdict.total_active      = open_total;
      verdict.sources_in_use    = 7'(in_use);
      verdict.sources_saturated = 7'(saturated);
      verdict.busiest_count     = busiest;
      verdict_q.push_back(verdict);
    endfunction

    function void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_beat(plc_pkg::out_item_t got);
      plc_pkg::out_item_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, actual %h",
                 $time, got);
        return;
      end
      want = verdict_q.pop_front();
      field_check("status", 16'(want.status), 16'(got.status));
      field_check("total_active", want.total_active, got.total_active);
      field_check("sources_in_use", 16'(want.sources_in_use), 16'(got.sources_in_use));
      field_check("sources_saturated", 16'(want.sources_saturated),
                  16'(got.sources_saturated));
      field_check("busiest_count", want.busiest_count, got.busiest_count);
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  plc_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  plc_pkg::out_item_t             out_data;
  logic                           cfg_we;
  logic [plc_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [plc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  admission_scoreboard            sb;
  logic [plc_pkg::KEY_W-1:0]      pool_up [POOL_SIZE];
  logic [plc_pkg::KEY_W-1:0]      pool_lo [POOL_SIZE];
  int                             idle_pct;
  int                             stall_pct;
  logic                           moved;
  int                             quiet;

  per_source_connection_limiter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(negedge clk) begin
    moved = rst_n && ((in_valid && in_ready) || (out_valid && out_ready));
    if (rst_n && out_valid && out_ready) begin
      sb.check_beat(out_data);
    end
  end

  always @(posedge clk) begin
    if (moved) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("[per_source_connection_limiter] ERROR");
      $finish;
    end
  end

  function automatic plc_pkg::in_item_t make_beat(logic act, logic [plc_pkg::KEY_W-1:0] up,
                                                   logic [plc_pkg::KEY_W-1:0] lo);
    plc_pkg::in_item_t b;
    b.action     = act;
    b.addr_upper = up;
    b.addr_lower = lo;
    return b;
  endfunction

  function automatic plc_pkg::in_item_t pick_beat(int pool_n, int acq_pct);
    plc_pkg::in_item_t b;
    int                k;
    if ($urandom_range(9) == 0) begin
      b.action     = 1'($urandom_range(1));
      b.addr_upper = {$urandom, $urandom};
      b.addr_lower = {$urandom, $urandom};
    end else begin
      k            = int'($urandom_range(pool_n - 1));
      b.action     = ($urandom_range(99) < acq_pct) ? plc_pkg::ACT_ACQUIRE
                                                    : plc_pkg::ACT_RELEASE;
      b.addr_upper = pool_up[k];
      b.addr_lower = pool_lo[k];
    end
    return b;
  endfunction

  task automatic send_beat(input plc_pkg::in_item_t b);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.admit_beat(b);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input plc_pkg::cfg_reg_t r,
                             input logic [plc_pkg::CFG_DATA_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(r, v);
  endtask

  task automatic run_phase(input int n, input int pool_n, input int acq_pct,
                           input int sender_idle, input int recv_stall);
    int i;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    for (i = 0; i < n; i++) begin
      send_beat(pick_beat(pool_n, acq_pct));
      if ($urandom_range(59) == 0) begin
        settle();
      end
    end
    settle();
  endtask

  initial begin
    int i;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    idle_pct  = 0;
    stall_pct = 0;
    moved     = 1'b0;
    quiet     = 0;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_up[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      if (i % 4 == 3) begin
        pool_up[i] = pool_up[i - 1];
      end else if (i % 5 == 4) begin
        pool_lo[i] = pool_lo[i - 1];
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    repeat (5) send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '0, '0));
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '1, '1));
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '1, '0));
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '0, '1));
    send_beat(make_beat(plc_pkg::ACT_RELEASE, '0, 64'd1));
    repeat (2) send_beat(make_beat(plc_pkg::ACT_RELEASE, '1, '1));
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd0);
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '0, '0));
    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd0);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'hFFFF);
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '0, '1));
    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd2);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd5);
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '1, '0));
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'hFFFF);
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '1, '0));
    send_beat(make_beat(plc_pkg::ACT_ACQUIRE, '0, '0));
    repeat (4) send_beat(make_beat(plc_pkg::ACT_RELEASE, '0, '0));
    send_beat(make_beat(plc_pkg::ACT_RELEASE, '1, '0));

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd4);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd256);
    run_phase(140, 16, 60, 0, 0);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd1);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'hFFFF);
    run_phase(150, 100, 80, 74, 0);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'hFFFF);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd12);
    run_phase(140, 8, 65, 0, 74);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd3);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd40);
    run_phase(140, 40, 60, 20, 20);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'hFFFF);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'hFFFF);
    run_phase(140, 100, 75, 0, 0);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd1);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd1);
    run_phase(40, 20, 60, 74, 0);

    write_limit(plc_pkg::REG_MAX_PER_SOURCE, 16'd5);
    write_limit(plc_pkg::REG_MAX_TOTAL, 16'd100);
    run_phase(100, 30, 50, 20, 20);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[per_source_connection_limiter] OK");
    end else begin
      $display("[per_source_connection_limiter] ERROR");
    end
    $finish;
  end

endmodule
